>>> hdl/mixed_objective_skyline_filter_defines.svh
// ----------------------------------------------------------------------------
// skyline filter assertion macros
// shared concurrent assertion forms for the skyline filter
// ----------------------------------------------------------------------------
`ifndef MIXED_OBJECTIVE_SKYLINE_FILTER_DEFINES_SVH
`define MIXED_OBJECTIVE_SKYLINE_FILTER_DEFINES_SVH

// implication checked on every edge outside reset
`define SKY_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define SKY_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/msf_pkg.sv
// ----------------------------------------------------------------------------
// skyline filter package
// shared widths, codes and command/status structs
// ----------------------------------------------------------------------------
package msf_pkg;
	localparam int SKY_DEPTH = 64;
	localparam int AW = $clog2(SKY_DEPTH);
	localparam int CW = $clog2(SKY_DEPTH + 1);
	localparam int OCW = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DUMP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_DOMINATED = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DUMPED    = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic [0:0] REG_MAX_DIMS = 1'd0;
	localparam logic [0:0] REG_MIN_DIMS = 1'd1;

	// controller to datapath
	typedef struct packed {
		logic       load;      // latch new vector, reset scan pointers
		logic       check;     // compare entry at read pointer for coverage only
		logic       rescan;    // restart read pointers at entry zero
		logic       scan;      // compare entry at read pointer, compact
		logic       append;    // write new vector at write pointer
		logic       commit;    // entry count <= write pointer
		logic       clear;     // entry count <= 0
		logic       rd_next;   // advance read pointer (dump)
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       scan_done;  // read pointer reached entry count
		logic       covered;    // a stored entry covers the new vector
		logic       rd_valid;   // registered read data valid
		logic       empty;      // entry count is zero
		logic       full;       // write pointer at depth
		logic       rd_last;    // entry being read is the last one
	} dp_sts_t;
endpackage

>>> hdl/msf_datapath.sv
// ----------------------------------------------------------------------------
// skyline datapath
// entry memory, dominance compare, compaction pointers and counters
// ----------------------------------------------------------------------------
module msf_datapath
	import msf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     max_dims,
	input  logic [2:0]     min_dims,
	input  logic [15:0]    val_a,
	input  logic [15:0]    val_b,
	input  logic [15:0]    val_c,
	input  logic [15:0]    val_d,
	input  logic [15:0]    hops,
	input  dp_cmd_t        cmd,
	output dp_sts_t        sts,
	output logic [63:0]    rd_vec,
	output logic [15:0]    rd_hops,
	output logic [OCW-1:0] evicted,
	output logic [OCW-1:0] set_size
);
	logic [63:0] vec_mem [SKY_DEPTH];
	logic [15:0] hop_mem [SKY_DEPTH];
	logic [63:0] new_vec_q;
	logic [15:0] new_hops_q;
	logic [CW-1:0] count_q, rptr_q, wptr_q, ev_q;
	logic [63:0] rvec_q;
	logic [15:0] rhop_q;
	logic [63:0] dvec_q;
	logic [15:0] dhop_q;
	logic        rvalid_q, covered_q;
	logic [CW-1:0] fetch_ptr;
	logic        fetch;
	logic        restart;
	logic [2:0]  mx, mn, nd;
	logic        s_cov_v, v_cov_s;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0] wr_vec;
	logic [15:0] wr_hop;

	// clamp dimension counts
	always_comb begin
		mx = (max_dims > 3'd4) ? 3'd4 : max_dims;
		mn = (min_dims > (3'd4 - mx)) ? (3'd4 - mx) : min_dims;
		nd = mx + mn;
	end

	// dominance in both directions between stored entry and new vector
	always_comb begin
		logic [15:0] sv, vv;
		s_cov_v = 1'b1;
		v_cov_s = 1'b1;
		for (int i = 0; i < 4; i++) begin
			sv = rvec_q[16*i +: 16];
			vv = new_vec_q[16*i +: 16];
			if (3'(i) < nd) begin
				if (3'(i) < mx) begin
					if (vv > sv) s_cov_v = 1'b0;
					if (sv > vv) v_cov_s = 1'b0;
				end else begin
					if (vv < sv) s_cov_v = 1'b0;
					if (sv < vv) v_cov_s = 1'b0;
				end
			end
		end
	end

	// read fetch: entry zero on load or rescan, then on each check, scan or dump step
	always_comb begin
		restart = cmd.load || cmd.rescan;
		fetch = restart || cmd.rd_next || ((cmd.scan || cmd.check) && rvalid_q);
		fetch_ptr = restart ? '0 : rptr_q;
	end

	// memory write: compaction move or append
	always_comb begin
		wr_en = 1'b0;
		wr_addr = wptr_q[AW-1:0];
		wr_vec = rvec_q;
		wr_hop = rhop_q;
		if (cmd.append && (wptr_q < CW'(SKY_DEPTH))) begin
			wr_en = 1'b1;
			wr_vec = new_vec_q;
			wr_hop = new_hops_q;
		end else if (cmd.scan && rvalid_q && !v_cov_s) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vec_mem[wr_addr] <= wr_vec;
			hop_mem[wr_addr] <= wr_hop;
		end
		if (fetch) begin
			rvec_q <= vec_mem[fetch_ptr[AW-1:0]];
			rhop_q <= hop_mem[fetch_ptr[AW-1:0]];
		end
		// dump data lines up with the registered result strobe
		dvec_q <= rvec_q;
		dhop_q <= rhop_q;
		if (cmd.load) begin
			new_vec_q <= {val_d, val_c, val_b, val_a};
			new_hops_q <= hops;
		end
	end

	// pointers, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rptr_q <= '0;
			wptr_q <= '0;
			ev_q <= '0;
			rvalid_q <= 1'b0;
			covered_q <= 1'b0;
		end else begin
			if (restart) begin
				rptr_q <= CW'(1);
				wptr_q <= '0;
				ev_q <= '0;
				covered_q <= 1'b0;
				rvalid_q <= (count_q != '0);
			end else if (cmd.rd_next) begin
				rptr_q <= rptr_q + CW'(1);
				rvalid_q <= 1'b1;
			end else if (cmd.check && rvalid_q) begin
				if (s_cov_v) covered_q <= 1'b1;
				rptr_q <= rptr_q + CW'(1);
				rvalid_q <= (rptr_q < count_q);
			end else if (cmd.scan && rvalid_q) begin
				if (v_cov_s) ev_q <= ev_q + CW'(1);
				else wptr_q <= wptr_q + CW'(1);
				rptr_q <= rptr_q + CW'(1);
				rvalid_q <= (rptr_q < count_q);
			end else if (cmd.append || cmd.commit) begin
				rvalid_q <= 1'b0;
			end
			if (cmd.clear) count_q <= '0;
			else if (cmd.append) count_q <= wptr_q + CW'(1);
			else if (cmd.commit) count_q <= wptr_q;
		end
	end

	always_comb begin
		sts.scan_done = !rvalid_q;
		sts.covered = covered_q || (rvalid_q && s_cov_v);
		sts.rd_valid = rvalid_q;
		sts.empty = (count_q == '0);
		sts.full = (wptr_q >= CW'(SKY_DEPTH));
		sts.rd_last = (rptr_q >= count_q);
	end

	assign rd_vec = dvec_q;
	assign rd_hops = dhop_q;
	assign evicted = OCW'(ev_q);
	assign set_size = OCW'(count_q);
endmodule

>>> hdl/msf_controller.sv
// ----------------------------------------------------------------------------
// skyline controller
// sequences insert scan, dump and clear and drives the result strobe
// ----------------------------------------------------------------------------
`include "mixed_objective_skyline_filter_defines.svh"
module msf_controller
	import msf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done,
	output logic [2:0] status,
	output logic       is_dump,
	output logic       last
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_FINISH = 3'd2;
	localparam logic [2:0] S_DUMP   = 3'd3;
	localparam logic [2:0] S_WAIT   = 3'd4;
	localparam logic [2:0] S_CHECK  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       done_d, last_d, dump_d;
	logic [2:0] status_d;
	logic       done_q, last_q, dump_q;
	logic [2:0] status_q;
	logic       fire;

	assign fire = start && !busy;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		done_d = 1'b0;
		last_d = 1'b1;
		dump_d = 1'b0;
		status_d = ST_ACCEPTED;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					if (command == CMD_INSERT) begin
						cmd.load = 1'b1;
						state_d = S_CHECK;
					end else if (command == CMD_DUMP) begin
						if (sts.empty) begin
							done_d = 1'b1;
							status_d = ST_EMPTY;
						end else begin
							cmd.load = 1'b1;
							state_d = S_DUMP;
						end
					end else if (command == CMD_CLEAR) begin
						cmd.clear = 1'b1;
						done_d = 1'b1;
						status_d = ST_EMPTY;
					end
				end
			end
			// first pass: look for a stored entry that covers the new vector
			S_CHECK: begin
				if (sts.covered) begin
					done_d = 1'b1;
					status_d = ST_DOMINATED;
					state_d = S_WAIT;
				end else if (sts.scan_done) begin
					cmd.rescan = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.check = 1'b1;
				end
			end
			// second pass: drop covered entries and compact the rest
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FINISH;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_FINISH: begin
				done_d = 1'b1;
				state_d = S_WAIT;
				if (sts.full) begin
					cmd.commit = 1'b1;
					status_d = ST_FULL;
				end else begin
					cmd.append = 1'b1;
				end
			end
			S_DUMP: begin
				done_d = 1'b1;
				dump_d = 1'b1;
				status_d = ST_DUMPED;
				last_d = sts.rd_last;
				if (sts.rd_last) state_d = S_WAIT;
				else cmd.rd_next = 1'b1;
			end
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			last_q <= 1'b0;
			dump_q <= 1'b0;
			status_q <= ST_ACCEPTED;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			last_q <= done_d && last_d;
			dump_q <= dump_d;
			status_q <= status_d;
		end
	end

	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign status = status_q;
	assign is_dump = dump_q;
	assign last = last_q;

	`SKY_ASSERT_IMP(a_no_start_busy, clk, arst_n, state_q != S_IDLE, busy,
		"busy low outside idle")
	`SKY_ASSERT_NEXT(a_scan_ends, clk, arst_n,
		(state_q == S_CHECK) && sts.covered, done_q && status_q == ST_DOMINATED,
		"dominated insert gave no result")
	`SKY_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd),
		"more than one datapath command")
endmodule

>>> hdl/mixed_objective_skyline_filter.sv
// ----------------------------------------------------------------------------
// mixed objective skyline filter
// pareto set of four-dimension labels with insert, dump and clear
// ----------------------------------------------------------------------------
// channel   signals                                      handshake
// command   start, busy, command, val_a..val_d, hops     start && !busy
// result    done, status, out_a..out_hops, evicted,       done, one cycle
//           set_size, last
// config    cfg_we, cfg_idx, cfg_data                    cfg_we
//
// insert: a coverage pass then a compaction pass over the n stored entries,
// one memory read per cycle; a dominated insert ends early.
// dump: one result per cycle after the first entry is fetched; clear empties the set.
// the entry memory has no reset; only entries below the count are read.
// the receiver cannot stall; busy covers the cycle of the final result.
module mixed_objective_skyline_filter
	import msf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] val_a,
	input  logic [15:0] val_b,
	input  logic [15:0] val_c,
	input  logic [15:0] val_d,
	input  logic [15:0] hops,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [2:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] out_a,
	output logic [15:0] out_b,
	output logic [15:0] out_c,
	output logic [15:0] out_d,
	output logic [15:0] out_hops,
	output logic [6:0]  evicted,
	output logic [6:0]  set_size,
	output logic        last
);
	logic [2:0] max_dims_q, min_dims_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [63:0] rd_vec;
	logic [15:0] rd_hops;
	logic [6:0] ev;
	logic is_dump;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dims_q <= 3'd1;
			min_dims_q <= 3'd1;
		end else if (cfg_we) begin
			if (cfg_idx == REG_MAX_DIMS) max_dims_q <= cfg_data;
			else min_dims_q <= cfg_data;
		end
	end

	msf_controller u_ctrl (
		.clk, .arst_n, .start, .command, .sts, .cmd, .busy, .done, .status,
		.is_dump, .last
	);

	msf_datapath u_dp (
		.clk, .arst_n, .max_dims(max_dims_q), .min_dims(min_dims_q),
		.val_a, .val_b, .val_c, .val_d, .hops, .cmd, .sts, .rd_vec, .rd_hops,
		.evicted(ev), .set_size
	);

	// dumped data only on dump results
	assign out_a = is_dump ? rd_vec[15:0] : 16'd0;
	assign out_b = is_dump ? rd_vec[31:16] : 16'd0;
	assign out_c = is_dump ? rd_vec[47:32] : 16'd0;
	assign out_d = is_dump ? rd_vec[63:48] : 16'd0;
	assign out_hops = is_dump ? rd_hops : 16'd0;
	assign evicted = (status == ST_ACCEPTED) ? ev : 7'd0;
endmodule
